// ===== src/ctk_pkg.sv =====
// Package: shared types, character codes, classifiers and the keyword list.
package ctk_pkg;

  localparam int KW_COUNT = 15;

  localparam logic [2:0] K_DELIM = 3'd0;
  localparam logic [2:0] K_OPER  = 3'd1;
  localparam logic [2:0] K_INT   = 3'd2;
  localparam logic [2:0] K_FLOAT = 3'd3;
  localparam logic [2:0] K_KWORD = 3'd4;
  localparam logic [2:0] K_IDENT = 3'd5;
  localparam logic [2:0] K_UNKN  = 3'd6;
  localparam logic [2:0] K_LINES = 3'd7;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;

  // Keywords, first character in the top byte, zero padded.
  localparam logic [63:0] KW_WORDS [KW_COUNT] = '{
    {"void", 32'h0}, {"int", 40'h0}, {"float", 24'h0}, {"double", 16'h0},
    {"short", 24'h0}, {"long", 32'h0}, {"if", 48'h0}, {"else", 32'h0},
    {"switch", 16'h0}, {"case", 32'h0}, {"break", 24'h0}, {"return", 16'h0},
    {"main", 32'h0}, {"static", 16'h0}, {"goto", 32'h0}
  };

  // Token header passed from scanner to resolver.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  first;
    logic [5:0]  len;
    logic        cut;
    logic [15:0] line;
    logic        ident;
    logic        clr;
    logic        last;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  first_char;
    logic [5:0]  lexeme_length;
    logic        lexeme_truncated;
    logic [3:0]  keyword_index;
    logic [5:0]  symbol_index;
    logic        symbol_added;
    logic        table_full;
    logic [15:0] line_value;
    logic        last;
  } out_item_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_LPAR || c == ")" || c == "{" || c == "}" || c == "[" ||
           c == "]" || c == CH_SEMI || c == ",";
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c == CH_PLUS || c == "=" || c == "-" || c == "*" || c == CH_SLASH ||
           c == "<" || c == ">";
  endfunction

endpackage

// ===== src/ctk_if.sv =====
// Interfaces: source byte channel and token channel.
interface ctk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;
  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface ctk_out_if;
  logic       valid;
  logic       ready;
  logic [2:0]  token_kind;
  logic [7:0]  first_char;
  logic [5:0]  lexeme_length;
  logic        lexeme_truncated;
  logic [3:0]  keyword_index;
  logic [5:0]  symbol_index;
  logic        symbol_added;
  logic        table_full;
  logic [15:0] line_value;
  logic        last;
  modport source (output valid, output token_kind, output first_char, output lexeme_length,
                  output lexeme_truncated, output keyword_index, output symbol_index,
                  output symbol_added, output table_full, output line_value,
                  output last, input ready);
  modport sink (input valid, input token_kind, input first_char, input lexeme_length,
                input lexeme_truncated, input keyword_index, input symbol_index,
                input symbol_added, input table_full, input line_value,
                input last, output ready);
endinterface

// ===== src/ctk_queue.sv =====
// Queue: four-entry token queue, up to two pushes and one pop per cycle.
module ctk_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_n,
  input  logic [W-1:0] wd0,
  input  logic [W-1:0] wd1,
  input  logic         pop,
  output logic         nonempty,
  output logic [W-1:0] rd,
  output logic [2:0]   level
);
  logic [W-1:0] ent [4];
  logic [1:0]   wp;
  logic [1:0]   rp;

  assign nonempty = level != 3'd0;
  assign rd = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 2'd0;
      rp <= 2'd0;
      level <= 3'd0;
    end else begin
      if (push_n != 2'd0) ent[wp] <= wd0;
      if (push_n == 2'd2) ent[wp + 2'd1] <= wd1;
      wp <= wp + push_n;
      if (pop) rp <= rp + 2'd1;
      level <= level + 3'(push_n) - 3'(pop);
    end
  end
endmodule

// ===== src/ctk_front.sv =====
// Scanner: groups bytes into lexemes and queues token jobs.
module ctk_front #(
  parameter int MAX_LEXEME = 49,
  parameter int KEEP = 19,
  parameter int CW = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [7:0]             c,
  input  logic                   eoi,
  output logic [1:0]             push_n,
  output ctk_pkg::hdr_t          h0,
  output ctk_pkg::hdr_t          h1,
  output logic [CW-1:0]          cnt0,
  output logic [KEEP-1:0][7:0]   ch0
);
  typedef enum logic [2:0] {M_IDLE, M_NUMBER, M_IDENT, M_SLASH, M_COMMENT} mode_t;

  mode_t               mode, mode_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic                cut, cut_next;
  logic                dot, dot_next;
  logic [15:0]         line, line_next;
  logic [KEEP-1:0][7:0] lex, lex_next;

  ctk_pkg::hdr_t fin, ib;
  logic          fin_v, ib_v, do_idle;

  function automatic ctk_pkg::hdr_t mk(input logic [2:0] k, input logic [7:0] f,
                                       input logic [5:0] l, input logic ct,
                                       input logic [15:0] ln);
    ctk_pkg::hdr_t h;
    h = '0;
    h.kind = k;
    h.first = f;
    h.len = l;
    h.cut = ct;
    h.line = ln;
    return h;
  endfunction

  always_comb begin
    mode_next = mode;
    cnt_next = cnt;
    cut_next = cut;
    dot_next = dot;
    line_next = line;
    lex_next = lex;
    fin_v = 1'b0;
    ib_v = 1'b0;
    do_idle = 1'b0;
    fin = mk(ctk_pkg::K_OPER, ctk_pkg::CH_SLASH, 6'd1, 1'b0, line);
    ib = mk(ctk_pkg::K_UNKN, c, 6'd1, 1'b0, line);
    if (mode == M_NUMBER || mode == M_IDENT) begin
      fin = mk(dot ? ctk_pkg::K_FLOAT : ctk_pkg::K_INT, lex[0], 6'(cnt), cut, line);
      fin.ident = mode == M_IDENT;
    end
    if (eoi) begin
      fin_v = mode == M_NUMBER || mode == M_IDENT || mode == M_SLASH;
      if (mode == M_COMMENT && line != 16'hffff) line_next = line + 16'd1;
      ib_v = 1'b1;
      ib = mk(ctk_pkg::K_LINES, 8'd0, 6'd0, 1'b0, line_next - 16'd1);
      ib.clr = 1'b1;
      mode_next = M_IDLE;
      cnt_next = '0;
      cut_next = 1'b0;
      dot_next = 1'b0;
      line_next = 16'd1;
    end else begin
      unique case (mode)
        M_COMMENT: begin
          if (c == ctk_pkg::CH_NL) begin
            if (line != 16'hffff) line_next = line + 16'd1;
            mode_next = M_IDLE;
          end
        end
        M_SLASH: begin
          if (c == ctk_pkg::CH_SLASH) mode_next = M_COMMENT;
          else begin
            fin_v = 1'b1;
            do_idle = 1'b1;
          end
        end
        M_NUMBER, M_IDENT: begin
          if ((mode == M_NUMBER && (ctk_pkg::is_digit(c) || c == ctk_pkg::CH_DOT)) ||
              (mode == M_IDENT && (ctk_pkg::is_alpha(c) || ctk_pkg::is_digit(c) ||
                                   c == ctk_pkg::CH_UNDER))) begin
            if (c == ctk_pkg::CH_DOT) dot_next = 1'b1;
            if (int'(cnt) < MAX_LEXEME) begin
              if (int'(cnt) < KEEP) lex_next[$clog2(KEEP)'(cnt)] = c;
              cnt_next = cnt + CW'(1);
            end else cut_next = 1'b1;
          end else begin
            fin_v = 1'b1;
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        mode_next = M_IDLE;
        if (c == ctk_pkg::CH_SLASH) mode_next = M_SLASH;
        else if (c == ctk_pkg::CH_SPACE || c == ctk_pkg::CH_TAB) begin
        end else if (c == ctk_pkg::CH_NL) begin
          if (line != 16'hffff) line_next = line + 16'd1;
        end else if (ctk_pkg::is_delim(c)) begin
          ib_v = 1'b1;
          ib.kind = ctk_pkg::K_DELIM;
        end else if (ctk_pkg::is_oper(c)) begin
          ib_v = 1'b1;
          ib.kind = ctk_pkg::K_OPER;
        end else if (ctk_pkg::is_digit(c) || ctk_pkg::is_alpha(c) ||
                     c == ctk_pkg::CH_UNDER) begin
          mode_next = ctk_pkg::is_digit(c) ? M_NUMBER : M_IDENT;
          lex_next = '0;
          lex_next[0] = c;
          cnt_next = CW'(1);
          cut_next = 1'b0;
          dot_next = 1'b0;
        end else ib_v = 1'b1;
      end
    end
    fin.last = !ib_v;
    ib.last = 1'b1;
  end

  always_comb begin
    push_n = take ? 2'(fin_v) + 2'(ib_v) : 2'd0;
    h0 = fin_v ? fin : ib;
    h1 = ib;
    cnt0 = cnt;
    ch0 = lex;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      cnt <= '0;
      cut <= 1'b0;
      dot <= 1'b0;
      line <= 16'd1;
    end else if (take) begin
      mode <= mode_next;
      cnt <= cnt_next;
      cut <= cut_next;
      dot <= dot_next;
      line <= line_next;
    end
    if (take) lex <= lex_next;
  end
endmodule

// ===== src/ctk_back.sv =====
// Resolver: keyword match, symbol table search and insert, output register.
module ctk_back #(
  parameter int SYMBOLS = 64,
  parameter int ID_CHARS = 19,
  parameter int KEEP = 19,
  parameter int CW = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  ctk_pkg::hdr_t         qh,
  input  logic [CW-1:0]         qcnt,
  input  logic [KEEP-1:0][7:0]  qch,
  output logic                  pop,
  output logic                  ov,
  input  logic                  oready,
  output ctk_pkg::out_item_t    ob
);
  localparam int SW  = SYMBOLS > 1 ? $clog2(SYMBOLS) : 1;
  localparam int SCW = $clog2(SYMBOLS + 1);
  localparam int LW  = $clog2(ID_CHARS + 1);
  localparam int RW  = ID_CHARS * 8 + LW;

  typedef enum logic [1:0] {B_IDLE, B_KW, B_RD, B_CMP} bst_t;

  bst_t                 st;
  logic [SCW-1:0]       sym_cnt;
  logic [SW-1:0]        s;
  ctk_pkg::hdr_t        jh;
  logic [CW-1:0]        jcnt;
  logic [KEEP-1:0][7:0] jch;
  logic [RW-1:0]        mem [SYMBOLS];
  logic [RW-1:0]        rdata;
  logic [RW-1:0]        row;
  logic [LW-1:0]        klen;
  logic [63:0]          w8;
  logic                 kw_hit, row_match, at_end, do_ins, ins_we;
  logic [3:0]           kw_idx;
  logic                 ov_set;
  ctk_pkg::out_item_t   ob_next;

  always_comb begin
    w8 = '0;
    for (int j = 0; j < 8; j++) w8[63 - 8*j -: 8] = jch[j];
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = 0; k < ctk_pkg::KW_COUNT; k++)
      if (!kw_hit && w8 == ctk_pkg::KW_WORDS[k]) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    kw_hit = kw_hit && !jh.cut;
    klen = (int'(jcnt) < ID_CHARS) ? LW'(jcnt) : LW'(ID_CHARS);
    row = {klen, jch[ID_CHARS-1:0]};
    row_match = rdata == row;
    at_end = (SCW'(s) + SCW'(1)) == sym_cnt;
    do_ins = (st == B_KW && !kw_hit && sym_cnt == '0) ||
             (st == B_CMP && !row_match && at_end);
    ins_we = do_ins && int'(sym_cnt) < SYMBOLS;
    pop = st == B_IDLE && q_valid && (!ov || oready);
  end

  function automatic ctk_pkg::out_item_t mk(input ctk_pkg::hdr_t h, input logic [2:0] k,
                                            input logic [3:0] kwi, input logic [5:0] symi,
                                            input logic added, input logic full);
    ctk_pkg::out_item_t o;
    o = '0;
    o.token_kind = k;
    o.first_char = h.first;
    o.lexeme_length = h.len;
    o.lexeme_truncated = h.cut;
    o.keyword_index = kwi;
    o.symbol_index = symi;
    o.symbol_added = added;
    o.table_full = full;
    o.line_value = h.line;
    o.last = h.last;
    return o;
  endfunction

  // result of this cycle, if any
  always_comb begin
    ov_set = 1'b0;
    ob_next = mk(qh, qh.kind, 4'd0, 6'd0, 1'b0, 1'b0);
    if (do_ins) begin
      ov_set = 1'b1;
      if (ins_we) ob_next = mk(jh, ctk_pkg::K_IDENT, 4'd0, 6'(sym_cnt), 1'b1, 1'b0);
      else ob_next = mk(jh, ctk_pkg::K_IDENT, 4'd0, 6'd0, 1'b0, 1'b1);
    end else if (st == B_IDLE) begin
      ov_set = pop && !qh.ident;
    end else if (st == B_KW) begin
      ov_set = kw_hit;
      ob_next = mk(jh, ctk_pkg::K_KWORD, kw_idx, 6'd0, 1'b0, 1'b0);
    end else if (st == B_CMP) begin
      ov_set = row_match;
      ob_next = mk(jh, ctk_pkg::K_IDENT, 4'd0, 6'(s), 1'b0, 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (st == B_RD) rdata <= mem[s];
    if (ins_we) mem[SW'(sym_cnt)] <= row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE;
      ov <= 1'b0;
      sym_cnt <= '0;
      s <= '0;
    end else begin
      ov <= ov_set || (ov && !oready);
      if (ov_set) ob <= ob_next;
      unique case (st)
        B_IDLE: begin
          if (pop) begin
            jh <= qh;
            jcnt <= qcnt;
            jch <= qch;
            if (qh.ident) st <= B_KW;
            else if (qh.clr) sym_cnt <= '0;
          end
        end
        B_KW: begin
          s <= '0;
          if (kw_hit) st <= B_IDLE;
          else if (sym_cnt != '0) st <= B_RD;
        end
        B_RD: st <= B_CMP;
        B_CMP: begin
          if (row_match) st <= B_IDLE;
          else if (!at_end) begin
            s <= s + SW'(1);
            st <= B_RD;
          end
        end
        default: st <= B_IDLE;
      endcase
      if (do_ins) begin
        st <= B_IDLE;
        if (ins_we) sym_cnt <= sym_cnt + SCW'(1);
      end
    end
  end
endmodule

// ===== src/c_like_lexical_tokenizer.sv =====
// Top level: C-like lexical tokenizer, scanner and resolver joined by a token queue.
//
// Usage:
//   in_ch carries one source byte (char_code) per transfer; a transfer with
//   end_of_input set flushes any pending token, then yields a line-count token
//   (kind 7) and returns the scanner state and the symbol table to reset.
//   out_ch carries one token per transfer; last marks the final token caused
//   by an input transfer (each input causes zero, one or two tokens).
// Timing:
//   The scanner takes one byte per cycle while the queue has two free slots.
//   Simple tokens go through the queue and are then loaded into the output register.
//   An identifier takes a keyword check, then for each symbol table entry searched
//   one registered row read and one compare, so throughput is set by the
//   symbol table search in the resolver and falls as the table fills.
// Reset:
//   rst (synchronous) empties the queue and output, sets line to 1 and the
//   symbol table count to 0. No clearing pass is needed.
// Stalls:
//   When out_ch.ready is low the token stays in the output register, the
//   resolver stops, the queue fills and then in_ch.ready drops.
module c_like_lexical_tokenizer #(
  parameter int MAX_LEXEME = 49,
  parameter int SYMBOLS = 64,
  parameter int ID_CHARS = 19
) (
  input logic clk,
  input logic rst,
  ctk_in_if.sink in_ch,
  ctk_out_if.source out_ch
);
  // kept characters: enough for identifiers and the longest keyword
  localparam int KEEP = ID_CHARS > 8 ? ID_CHARS : 8;
  localparam int CW   = $clog2(MAX_LEXEME + 1);
  localparam int HW   = $bits(ctk_pkg::hdr_t);
  localparam int QW   = HW + CW + KEEP * 8;

  logic [1:0]            push_n;
  ctk_pkg::hdr_t         h0, h1, qh;
  logic [CW-1:0]         cnt0, qcnt;
  logic [KEEP-1:0][7:0]  ch0, qch;
  logic [QW-1:0]         qrd;
  logic                  q_valid, pop, take, ov;
  logic [2:0]            q_level;
  ctk_pkg::out_item_t    ob;

  // scanner may push two jobs per byte, so it needs two free slots
  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = q_level <= 3'd2;

  ctk_front #(.MAX_LEXEME(MAX_LEXEME), .KEEP(KEEP), .CW(CW)) u_front (
    .clk(clk), .rst(rst), .take(take), .c(in_ch.char_code), .eoi(in_ch.end_of_input),
    .push_n(push_n), .h0(h0), .h1(h1), .cnt0(cnt0), .ch0(ch0)
  );

  // second job of a byte is never an identifier, so its lexeme part is don't-care
  ctk_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst), .push_n(push_n),
    .wd0({h0, cnt0, ch0}), .wd1({h1, cnt0, ch0}),
    .pop(pop), .nonempty(q_valid), .rd(qrd), .level(q_level)
  );

  assign {qh, qcnt, qch} = qrd;

  ctk_back #(.SYMBOLS(SYMBOLS), .ID_CHARS(ID_CHARS), .KEEP(KEEP), .CW(CW)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .qh(qh), .qcnt(qcnt), .qch(qch),
    .pop(pop), .ov(ov), .oready(out_ch.ready), .ob(ob)
  );

  assign out_ch.valid = ov;
  assign out_ch.token_kind = ob.token_kind;
  assign out_ch.first_char = ob.first_char;
  assign out_ch.lexeme_length = ob.lexeme_length;
  assign out_ch.lexeme_truncated = ob.lexeme_truncated;
  assign out_ch.keyword_index = ob.keyword_index;
  assign out_ch.symbol_index = ob.symbol_index;
  assign out_ch.symbol_added = ob.symbol_added;
  assign out_ch.table_full = ob.table_full;
  assign out_ch.line_value = ob.line_value;
  assign out_ch.last = ob.last;

  // queue never overflows
  a_q_bound: assert property (@(posedge clk) disable iff (rst) q_level <= 3'd4)
    else $error("token queue overflow");

  // a byte is only taken with room for two jobs
  a_take_room: assert property (@(posedge clk) disable iff (rst) take |-> q_level <= 3'd2)
    else $error("byte taken without queue room");

  // no pop from an empty queue
  a_pop_ok: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");

  // output register is empty after reset
  a_rst_out: assert property (@(posedge clk) $past(rst) |-> !out_ch.valid)
    else $error("token valid after reset");
endmodule
